[rtl/tar_pkg.sv]
// shared types and constants for the tensor axis reduction block
`timescale 1ns / 1ps

package tar_pkg;

    localparam int VAL_W      = 32;  // element width, signed q16.16
    localparam int ACC_W      = 48;  // accumulator and result width
    localparam int POS_W      = 16;  // axis position and length width
    localparam int OP_W       = 3;
    localparam int INNER_W    = 11;  // inner count register width
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // reduction codes
    localparam logic [OP_W-1:0] OP_SUM    = 3'd0;
    localparam logic [OP_W-1:0] OP_MEAN   = 3'd1;
    localparam logic [OP_W-1:0] OP_MAX    = 3'd2;
    localparam logic [OP_W-1:0] OP_MIN    = 3'd3;
    localparam logic [OP_W-1:0] OP_ARGMAX = 3'd4;
    localparam logic [OP_W-1:0] OP_ARGMIN = 3'd5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INNER  = 2'd2;

    // effective configuration, already clamped to legal values
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [POS_W-1:0]   len;
        logic [INNER_W-1:0] inner;
    } t_cfg;

endpackage

[rtl/tar_if.sv]
// channel interfaces: element input, result output, register write
`timescale 1ns / 1ps

interface tar_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [tar_pkg::VAL_W-1:0]    element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

interface tar_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [tar_pkg::ACC_W-1:0]    result_value;
    logic        [tar_pkg::POS_W-1:0]    result_index;

    modport source (output valid, output result_value, output result_index, input ready);
    modport sink   (input valid, input result_value, input result_index, output ready);
endinterface

interface tar_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [tar_pkg::CFG_IDX_W-1:0]       index;
    logic [tar_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/tensor_axis_reduction_top.sv]
// top level of the tensor axis reduction block
`timescale 1ns / 1ps

// Streams a contiguous tensor in memory order and reduces it along one axis:
// sum, mean, max, min, argmax or argmin over signed q16.16 elements, one
// 48-bit accumulator and one best position per inner position. Program
// reduce_op, reduce_length and inner_count through the register channel while
// the block is idle; every write to a known register index restarts the tensor
// at element zero. One result beat comes out when the last element along the
// axis for an inner position arrives; its index is the first extreme position
// for max, min, argmax and argmin, and zero for sum and mean. The front end
// takes one element a cycle into a four-entry queue while it is not full. The
// back end reads the accumulator memory, then updates and writes back through
// its single port, and takes no new element before the write-back; an element
// that closes an axis adds a result step, held while the output slot is full,
// and for mean the bit-serial divider runs first, one quotient bit a cycle.
module tensor_axis_reduction_top #(
    parameter int INNER_MAX = 1024,
    parameter int AXIS_MAX  = 65535
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tar_in_if.sink     i_in,
    tar_out_if.source  o_out,
    tar_cfg_if.sink    i_cfg
);
    import tar_pkg::*;

    localparam int ADDR_W     = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1;
    localparam int ITEM_W     = VAL_W + ADDR_W + POS_W + 2;
    localparam int QUEUE_DEPTH = 4;

    // configuration registers
    logic [OP_W-1:0]    r_op;
    logic [POS_W-1:0]   r_len;
    logic [INNER_W-1:0] r_inner;
    logic               cfg_wr;
    t_cfg               cfg;

    // front to queue to back
    logic               push;
    logic [ITEM_W-1:0]  push_item;
    logic               pop;
    logic [ITEM_W-1:0]  pop_item;
    logic               q_full;
    logic               q_empty;

    assign i_cfg.ready = 1'b1;

    // only known indexes restart the stream
    assign cfg_wr = i_cfg.valid
                 && (i_cfg.index == REG_OP || i_cfg.index == REG_LENGTH
                     || i_cfg.index == REG_INNER);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op    <= OP_SUM;
            r_len   <= 16'd1;
            r_inner <= 11'd1;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_OP:     r_op    <= i_cfg.data[OP_W-1:0];
                REG_LENGTH: r_len   <= i_cfg.data[POS_W-1:0];
                REG_INNER:  r_inner <= i_cfg.data[INNER_W-1:0];
                default:    ;
            endcase
        end
    end

    // clamp to the legal ranges: unused op codes reduce as sum,
    // zero counts act as one, oversize counts saturate at the bound
    always_comb begin
        cfg.op = (r_op > OP_ARGMIN) ? OP_SUM : r_op;

        if (r_len == '0) begin
            cfg.len = 16'd1;
        end else if (32'(r_len) > AXIS_MAX) begin
            cfg.len = POS_W'(AXIS_MAX);
        end else begin
            cfg.len = r_len;
        end

        if (r_inner == '0) begin
            cfg.inner = 11'd1;
        end else if (32'(r_inner) > INNER_MAX) begin
            cfg.inner = INNER_W'(INNER_MAX);
        end else begin
            cfg.inner = r_inner;
        end
    end

    tar_front #(
        .ADDR_W (ADDR_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (cfg),
        .i_cfg_wr (cfg_wr),
        .i_full   (q_full),
        .o_push   (push),
        .o_item   (push_item)
    );

    tar_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_item),
        .i_pop   (pop),
        .o_data  (pop_item),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    tar_back #(
        .INNER_MAX (INNER_MAX)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_item  (pop_item),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

[rtl/tar_front.sv]
// front end: accepts elements and tags them with inner and axis position
`timescale 1ns / 1ps

module tar_front #(
    parameter int ADDR_W = 10,
    localparam int ITEM_W = tar_pkg::VAL_W + ADDR_W + tar_pkg::POS_W + 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tar_in_if.sink             i_in,
    input  tar_pkg::t_cfg      i_cfg,
    input  logic               i_cfg_wr,
    input  logic               i_full,
    output logic               o_push,
    output logic [ITEM_W-1:0]  o_item
);
    import tar_pkg::*;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [ADDR_W-1:0]       ip;
        logic [POS_W-1:0]        ax;
        logic                    first;
        logic                    last;
    } t_item;

    logic [ADDR_W-1:0] r_ip;
    logic [POS_W-1:0]  r_ax;
    logic              accept;
    logic              ip_last;
    logic              ax_last;
    t_item             item;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign ip_last    = 32'(r_ip) == (32'(i_cfg.inner) - 32'd1);
    assign ax_last    = r_ax == (i_cfg.len - 16'd1);

    always_comb begin
        item.value = i_in.element_value;
        item.ip    = r_ip;
        item.ax    = r_ax;
        item.first = r_ax == '0;
        item.last  = ax_last;
    end

    assign o_push = accept;
    assign o_item = item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ip <= '0;
            r_ax <= '0;
        end else if (i_cfg_wr) begin
            r_ip <= '0;
            r_ax <= '0;
        end else if (accept) begin
            if (ip_last) begin
                r_ip <= '0;
                r_ax <= ax_last ? '0 : r_ax + 16'd1;
            end else begin
                r_ip <= r_ip + ADDR_W'(1);
            end
        end
    end

endmodule

[rtl/tar_fifo.sv]
// small register queue between the front end and the back end
`timescale 1ns / 1ps

module tar_fifo #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [PW:0]      r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = r_count == (PW+1)'(DEPTH);
    assign o_empty = r_count == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (32'(r_wr_ptr) == DEPTH - 1) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (32'(r_rd_ptr) == DEPTH - 1) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (PW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (PW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[rtl/tar_div.sv]
// bit-serial signed divide of the sum by the axis length, truncating toward zero
`timescale 1ns / 1ps

module tar_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [tar_pkg::ACC_W-1:0] i_dividend,
    input  logic        [tar_pkg::POS_W-1:0] i_divisor,
    output logic                             o_done,
    output logic signed [tar_pkg::ACC_W-1:0] o_quotient
);
    import tar_pkg::*;

    localparam int CNT_W = $clog2(ACC_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [ACC_W-1:0] r_quo;
    logic [POS_W:0]   r_rem;
    logic             r_neg;
    logic [POS_W-1:0] r_div;
    logic [POS_W:0]   rem_sh;
    logic             q_bit;
    logic [POS_W:0]   n_rem;

    always_comb begin
        rem_sh = {r_rem[POS_W-1:0], r_quo[ACC_W-1]};
        q_bit  = rem_sh >= {1'b0, r_div};
        n_rem  = q_bit ? rem_sh - {1'b0, r_div} : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(ACC_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // magnitude divide, sign restored at the output
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend[ACC_W-1] ? -i_dividend : i_dividend;
            r_neg <= i_dividend[ACC_W-1];
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[ACC_W-2:0], q_bit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -r_quo : r_quo;

endmodule

[rtl/tar_back.sv]
// back end: per-position read-modify-write of the accumulators and result register
`timescale 1ns / 1ps

module tar_back #(
    parameter int INNER_MAX = 1024,
    localparam int ADDR_W = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1,
    localparam int ITEM_W = tar_pkg::VAL_W + ADDR_W + tar_pkg::POS_W + 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tar_pkg::t_cfg      i_cfg,
    input  logic [ITEM_W-1:0]  i_item,
    input  logic               i_empty,
    output logic               o_pop,
    tar_out_if.source          o_out
);
    import tar_pkg::*;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [ADDR_W-1:0]       ip;
        logic [POS_W-1:0]        ax;
        logic                    first;
        logic                    last;
    } t_item;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_UPD  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic signed [ACC_W-1:0] r_acc_mem  [INNER_MAX];
    logic        [POS_W-1:0] r_best_mem [INNER_MAX];

    logic [1:0]              r_state;
    logic [1:0]              n_state;
    t_item                   item;
    t_item                   r_item;
    logic signed [ACC_W-1:0] r_rd_acc;
    logic        [POS_W-1:0] r_rd_best;
    logic signed [ACC_W-1:0] r_acc;
    logic        [POS_W-1:0] r_best;
    logic signed [ACC_W-1:0] n_acc;
    logic        [POS_W-1:0] n_best;
    logic signed [ACC_W-1:0] v48;
    logic                    is_sum;
    logic                    div_start;
    logic                    div_done;
    logic signed [ACC_W-1:0] div_q;
    logic                    r_out_valid;
    logic signed [ACC_W-1:0] r_out_value;
    logic        [POS_W-1:0] r_out_index;
    logic                    slot_free;
    logic                    load_out;

    assign item      = t_item'(i_item);
    assign o_pop     = (r_state == ST_IDLE) && !i_empty;
    assign is_sum    = i_cfg.op inside {OP_SUM, OP_MEAN};
    assign v48       = {{(ACC_W - VAL_W){r_item.value[VAL_W-1]}}, r_item.value};
    assign slot_free = !r_out_valid || o_out.ready;
    assign load_out  = (r_state == ST_OUT) && slot_free;
    assign div_start = (r_state == ST_UPD) && r_item.last && (i_cfg.op == OP_MEAN);

    // update rule; ties keep the earlier position
    always_comb begin
        n_acc  = r_rd_acc;
        n_best = r_rd_best;
        if (r_item.first) begin
            n_acc  = v48;
            n_best = '0;
        end else if (is_sum) begin
            n_acc = r_rd_acc + v48;
        end else if (i_cfg.op inside {OP_MAX, OP_ARGMAX}) begin
            if (v48 > r_rd_acc) begin
                n_acc  = v48;
                n_best = r_item.ax;
            end
        end else begin
            if (v48 < r_rd_acc) begin
                n_acc  = v48;
                n_best = r_item.ax;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                if (!r_item.last) begin
                    n_state = ST_IDLE;
                end else if (i_cfg.op == OP_MEAN) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item    <= item;
            r_rd_acc  <= r_acc_mem[item.ip];
            r_rd_best <= r_best_mem[item.ip];
        end
        if (r_state == ST_UPD) begin
            r_acc_mem[r_item.ip]  <= n_acc;
            r_best_mem[r_item.ip] <= n_best;
            r_acc                 <= n_acc;
            r_best                <= n_best;
        end
        if ((r_state == ST_DIV) && div_done) begin
            r_acc <= div_q;
        end
        if (load_out) begin
            r_out_value <= r_acc;
            r_out_index <= is_sum ? '0 : r_best;
        end
    end

    tar_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_acc),
        .i_divisor  (i_cfg.len),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign o_out.valid        = r_out_valid;
    assign o_out.result_value = r_out_value;
    assign o_out.result_index = r_out_index;

endmodule

[verif/testbench.sv]
// self-checking testbench for the tensor axis reduction block
`timescale 1ns / 1ps

module testbench;
    import tar_pkg::*;

    // block sizes, passed to the top level
    localparam int INNER_MAX = 1024;
    localparam int AXIS_MAX  = 65535;

    // random beats after the directed table
    localparam int RANDOM_ITEMS = 1925;
    // element queue drain plus the result step that closes an axis plus the bit-serial mean divider
    localparam int SETTLE_CYCLES = 120;
    // cycles with no handshake on any channel before the run is abandoned
    localparam int QUIET_LIMIT = 3000;

    // index past the register list, ignored by the block
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    // unused operation code, behaves as sum
    localparam logic [OP_W-1:0] OP_SPARE = 3'd7;

    typedef struct packed {
        logic signed [ACC_W-1:0] value;
        logic        [POS_W-1:0] index;
    } t_reduction;

    typedef enum logic [1:0] {
        ROW_REG,          // register write
        ROW_ELEM,         // element beat, result (if any) from the predictor
        ROW_ELEM_TYPED    // element beat that closes an axis, result typed in
    } t_row_kind;

    typedef struct packed {
        t_row_kind                kind;
        logic [CFG_IDX_W-1:0]     idx;
        logic [CFG_DATA_W-1:0]    data;
        logic signed [VAL_W-1:0]  element;
        t_reduction               typed;
    } t_stim_row;

    // directed table, walked top to bottom right after reset
    localparam int DIRECTED_ROWS = 42;
    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        // reset values: sum, length one, inner one, so every beat closes an axis
        '{ROW_ELEM_TYPED, REG_OP, '0, 32'sh7FFF_FFFF, '{48'sh0000_7FFF_FFFF, 16'd0}},
        '{ROW_ELEM_TYPED, REG_OP, '0, 32'sh8000_0000, '{48'shFFFF_8000_0000, 16'd0}},
        '{ROW_ELEM_TYPED, REG_OP, '0, -32'sd1,        '{48'shFFFF_FFFF_FFFF, 16'd0}},
        // unused op code acts as a plain sum
        '{ROW_REG,        REG_OP,     16'(OP_SPARE), '0, '0},
        '{ROW_REG,        REG_LENGTH, 16'd2,         '0, '0},
        '{ROW_ELEM,       REG_OP, '0, 32'sd5,  '0},
        '{ROW_ELEM,       REG_OP, '0, -32'sd3, '0},
        // zero length behaves as length one
        '{ROW_REG,        REG_LENGTH, 16'd0, '0, '0},
        '{ROW_ELEM_TYPED, REG_OP, '0, 32'sd9, '{48'sd9, 16'd0}},
        // mean truncates toward zero on both signs
        '{ROW_REG,        REG_OP,     16'(OP_MEAN), '0, '0},
        '{ROW_REG,        REG_LENGTH, 16'd2,        '0, '0},
        '{ROW_ELEM,       REG_OP, '0, 32'sd7,  '0},
        '{ROW_ELEM_TYPED, REG_OP, '0, 32'sd0,  '{48'sd3, 16'd0}},
        '{ROW_ELEM,       REG_OP, '0, -32'sd7, '0},
        '{ROW_ELEM_TYPED, REG_OP, '0, 32'sd0,  '{48'shFFFF_FFFF_FFFD, 16'd0}},
        // max over two interleaved inner positions, ties keep the first
        '{ROW_REG,        REG_OP,     16'(OP_MAX), '0, '0},
        '{ROW_REG,        REG_LENGTH, 16'd3,       '0, '0},
        '{ROW_REG,        REG_INNER,  16'd2,       '0, '0},
        '{ROW_ELEM,       REG_OP, '0, 32'sd4,  '0},
        '{ROW_ELEM,       REG_OP, '0, -32'sd1, '0},
        '{ROW_ELEM,       REG_OP, '0, 32'sd4,  '0},
        '{ROW_ELEM,       REG_OP, '0, 32'sd5,  '0},
        '{ROW_ELEM_TYPED, REG_OP, '0, 32'sd1,  '{48'sd4, 16'd0}},
        '{ROW_ELEM_TYPED, REG_OP, '0, 32'sd5,  '{48'sd5, 16'd1}},
        // argmin across the full element range, zero inner count acts as one
        '{ROW_REG,        REG_OP,     16'(OP_ARGMIN), '0, '0},
        '{ROW_REG,        REG_LENGTH, 16'd2,          '0, '0},
        '{ROW_REG,        REG_INNER,  16'd0,          '0, '0},
        '{ROW_ELEM,       REG_OP, '0, 32'sh7FFF_FFFF, '0},
        '{ROW_ELEM_TYPED, REG_OP, '0, 32'sh8000_0000, '{48'shFFFF_8000_0000, 16'd1}},
        // argmax
        '{ROW_REG,        REG_OP, 16'(OP_ARGMAX), '0, '0},
        '{ROW_ELEM,       REG_OP, '0, -32'sd5, '0},
        '{ROW_ELEM_TYPED, REG_OP, '0, 32'sd0,  '{48'sd0, 16'd1}},
        // write to an unknown index mid-axis leaves the position alone
        '{ROW_ELEM,       REG_OP, '0, 32'sd1, '0},
        '{ROW_REG,        REG_SPARE, 16'hFFFF, '0, '0},
        '{ROW_ELEM_TYPED, REG_OP, '0, 32'sd2, '{48'sd2, 16'd1}},
        // a real register write mid-axis restarts the tensor
        '{ROW_ELEM,       REG_OP, '0, 32'sd3, '0},
        '{ROW_REG,        REG_OP, 16'(OP_ARGMAX), '0, '0},
        '{ROW_ELEM,       REG_OP, '0, -32'sd1, '0},
        '{ROW_ELEM_TYPED, REG_OP, '0, -32'sd2, '{48'shFFFF_FFFF_FFFF, 16'd0}},
        // min with a tie
        '{ROW_REG,        REG_OP, 16'(OP_MIN), '0, '0},
        '{ROW_ELEM,       REG_OP, '0, 32'sd3, '0},
        '{ROW_ELEM_TYPED, REG_OP, '0, 32'sd3, '{48'sd3, 16'd0}}
    };

    logic i_clk;
    logic i_rst_n;

    tar_in_if  in_if ();
    tar_out_if out_if ();
    tar_cfg_if cfg_if ();

    tensor_axis_reduction_top #(
        .INNER_MAX (INNER_MAX),
        .AXIS_MAX  (AXIS_MAX)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // predictor state: raw register values and per inner position accumulators
    logic [OP_W-1:0]          cfg_op;
    logic [POS_W-1:0]         cfg_len;
    logic [INNER_W-1:0]       cfg_inner;
    logic signed [ACC_W-1:0]  acc_mem [INNER_MAX];
    logic [POS_W-1:0]         best_mem [INNER_MAX];
    int unsigned              inner_pos;
    int unsigned              axis_pos;

    // reductions predicted but not yet seen on the output, oldest first
    t_reduction reductions_due [$];
    int         mismatch_count = 0;
    int         burst_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // register values as the block applies them
    function automatic int unsigned span_length(input logic [POS_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > AXIS_MAX)
            return AXIS_MAX;
        return raw;
    endfunction

    function automatic int unsigned span_inner(input logic [INNER_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > INNER_MAX)
            return INNER_MAX;
        return raw;
    endfunction

    // fold one element into its inner position; reports the reduction when the
    // element is the last one along the axis
    task automatic fold_element(input logic signed [VAL_W-1:0] v, output bit produced,
                                output t_reduction r);
        int unsigned     len;
        int unsigned     inn;
        int unsigned     ip;
        int unsigned     ax;
        logic [OP_W-1:0] op;
        longint          wide;
        len = span_length(cfg_len);
        inn = span_inner(cfg_inner);
        op = (cfg_op > OP_ARGMIN) ? OP_SUM : cfg_op;
        ip = (inner_pos >= inn) ? 0 : inner_pos;
        ax = (axis_pos >= len) ? 0 : axis_pos;
        produced = 1'b0;
        r = '0;

        // first element along the axis seeds the accumulator
        if (ax == 0) begin
            acc_mem[ip] = v;
            best_mem[ip] = '0;
        end else if (op == OP_SUM || op == OP_MEAN) begin
            acc_mem[ip] = acc_mem[ip] + v;
        end else if (op == OP_MAX || op == OP_ARGMAX) begin
            if (v > acc_mem[ip]) begin
                acc_mem[ip] = v;
                best_mem[ip] = POS_W'(ax);
            end
        end else begin
            if (v < acc_mem[ip]) begin
                acc_mem[ip] = v;
                best_mem[ip] = POS_W'(ax);
            end
        end

        if (ax == len - 1) begin
            wide = acc_mem[ip];
            if (op == OP_MEAN)
                wide = wide / longint'(len);
            r.value = wide[ACC_W-1:0];
            r.index = (op == OP_SUM || op == OP_MEAN) ? '0 : best_mem[ip];
            produced = 1'b1;
        end

        // inner position runs fastest, axis steps on its wrap
        ip++;
        if (ip >= inn) begin
            ip = 0;
            ax++;
            if (ax >= len)
                ax = 0;
        end
        inner_pos = ip;
        axis_pos = ax;
    endtask

    // drop valid if a burst is still open, so a stale beat is never resent
    task automatic close_burst();
        if (burst_left != 0) begin
            in_if.valid <= 1'b0;
            burst_left = 0;
        end
    endtask

    // send one element beat; bursts of back-to-back beats with idle gaps between
    task automatic send_element(input logic signed [VAL_W-1:0] v, input bit use_typed,
                                input t_reduction typed);
        bit         produced;
        t_reduction r;
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 16);
        end
        in_if.valid <= 1'b1;
        in_if.element_value <= v;
        do @(posedge i_clk); while (!(in_if.valid && in_if.ready));
        burst_left--;
        if (burst_left == 0)
            in_if.valid <= 1'b0;
        fold_element(v, produced, r);
        if (produced) begin
            if (use_typed)
                r = typed;
            reductions_due = {reductions_due, r};
        end
    endtask

    // register write, only once the block has gone quiet
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        close_burst();
        while (reductions_due.size() != 0) @(posedge i_clk);
        // a partial axis leaves elements in flight with no result to wait for
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= value;
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
        cfg_if.valid <= 1'b0;
        case (idx)
            REG_OP:     cfg_op = value[OP_W-1:0];
            REG_LENGTH: cfg_len = value[POS_W-1:0];
            REG_INNER:  cfg_inner = value[INNER_W-1:0];
            default:    return;
        endcase
        inner_pos = 0;
        axis_pos = 0;
    endtask

    // element values: extremes, small values that tie often, full range
    function automatic logic signed [VAL_W-1:0] pick_element();
        case ($urandom_range(0, 7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3:    return VAL_W'($urandom_range(0, 8) - 4);
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // result side: check every beat, stall on its own pattern, watch for hangs
    initial begin : result_side
        t_reduction  want;
        bit          sink_open;
        int          run_left;
        int          quiet_cycles;
        sink_open = 1'b0;
        run_left = 0;
        quiet_cycles = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_if.valid && out_if.ready) begin
                if (reductions_due.size() == 0) begin
                    $error("result beat with nothing pending: value %0d index %0d",
                           out_if.result_value, out_if.result_index);
                    mismatch_count++;
                end else begin
                    want = reductions_due.pop_front();
                    if (out_if.result_value !== want.value) begin
                        $error("result_value expected %0d actual %0d",
                               want.value, out_if.result_value);
                        mismatch_count++;
                    end
                    if (out_if.result_index !== want.index) begin
                        $error("result_index expected %0d actual %0d",
                               want.index, out_if.result_index);
                        mismatch_count++;
                    end
                end
            end

            // watchdog on any handshake across the three channels
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end

            // alternate open and stalled stretches, now and then a long open one
            if (run_left == 0) begin
                sink_open = !sink_open;
                if (sink_open)
                    run_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150)
                                                           : $urandom_range(1, 20);
                else
                    run_left = $urandom_range(1, 10);
            end
            run_left--;
            out_if.ready <= sink_open;
        end
    end

    // stimulus: reset, directed table, random phases, drain
    initial begin : stimulus
        int unsigned phase;
        int unsigned sent;
        int unsigned pick;
        int unsigned op_raw;
        int unsigned len_raw;
        int unsigned inner_raw;
        int unsigned tensor_size;
        int unsigned reps;
        int unsigned count;

        i_rst_n <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.element_value <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= '0;
        cfg_if.data <= '0;
        cfg_op = OP_SUM;
        cfg_len = 16'd1;
        cfg_inner = 11'd1;
        inner_pos = 0;
        axis_pos = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            case (DIRECTED[i].kind)
                ROW_REG:        write_register(DIRECTED[i].idx, DIRECTED[i].data);
                ROW_ELEM:       send_element(DIRECTED[i].element, 1'b0, '0);
                ROW_ELEM_TYPED: send_element(DIRECTED[i].element, 1'b1, DIRECTED[i].typed);
                default:        ;
            endcase
        end

        // random phases: fresh settings, then whole tensors with random content;
        // some phases end mid-axis so the next write lands mid-stream
        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            phase++;
            op_raw = $urandom_range(0, 7);
            if (phase == 3) begin
                // widest inner stride, past the wrap of the last inner position
                len_raw = 2;
                inner_raw = $urandom_range(INNER_MAX, 2047);
                count = INNER_MAX + $urandom_range(1, 64);
            end else if (phase == 6) begin
                // longest axis, only a slice of it
                len_raw = AXIS_MAX;
                inner_raw = 1;
                count = $urandom_range(20, 60);
            end else begin
                pick = $urandom_range(0, 19);
                len_raw = (pick < 13) ? $urandom_range(1, 6) :
                          (pick < 16) ? $urandom_range(7, 40) :
                          (pick == 16) ? 0 :
                          (pick < 19) ? $urandom_range(41, 200) : $urandom_range(0, 65535);
                pick = $urandom_range(0, 19);
                inner_raw = (pick < 14) ? $urandom_range(1, 4) :
                            (pick < 17) ? $urandom_range(5, 24) :
                            (pick == 17) ? 0 :
                            (pick == 18) ? $urandom_range(0, 2047) : 1;
                tensor_size = span_length(POS_W'(len_raw)) * span_inner(INNER_W'(inner_raw));
                if (tensor_size > 300) begin
                    count = $urandom_range(1, 300);
                end else begin
                    reps = 300 / tensor_size;
                    reps = (reps > 4) ? 4 : reps;
                    count = tensor_size * $urandom_range(1, reps);
                    // broken tail: a partial tensor before the next settings
                    if (tensor_size > 1 && $urandom_range(0, 5) == 0)
                        count += $urandom_range(1, tensor_size - 1);
                end
            end
            // keep the total close to the planned number of beats
            if (count > RANDOM_ITEMS - sent)
                count = RANDOM_ITEMS - sent;

            write_register(REG_OP, CFG_DATA_W'(op_raw));
            write_register(REG_LENGTH, CFG_DATA_W'(len_raw));
            write_register(REG_INNER, CFG_DATA_W'(inner_raw));
            if ($urandom_range(0, 4) == 0)
                write_register(REG_SPARE, CFG_DATA_W'($urandom));

            repeat (count) begin
                send_element(pick_element(), 1'b0, '0);
                sent++;
            end
        end

        // drain, then give the block time to show any stray beat
        close_burst();
        while (reductions_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && reductions_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
